// ----- sv/amsm_pkg.sv -----
// ----------------------------------------------------------------------------
// amsm_pkg
// Types and constants shared by the sensor min/max monitor files.
// ----------------------------------------------------------------------------
package amsm_pkg;

  // Reading kinds
  typedef enum logic [1:0] {
    OP_TEMP = 2'd0,
    OP_VOLT = 2'd1,
    OP_CURR = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  // Configuration register map (index = paddr[3:2])
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_MON_EN  = 2'd0;
  localparam logic [1:0] REG_DBL_CH  = 2'd1;
  localparam logic [1:0] REG_DBL_EN  = 2'd2;

  // Reciprocal of 125 for 18-bit dividends: q = (x * RECIP_125) >> RECIP_SHIFT
  localparam logic [18:0] RECIP_125   = 19'd268436;
  localparam int unsigned RECIP_SHIFT = 25;

  localparam logic [15:0] VALUE_MAX = 16'hFFFF;

  typedef struct packed {
    logic       mon_en;
    logic [3:0] dbl_ch;
    logic       dbl_en;
  } cfg_t;

  typedef struct packed {
    op_e                operation;
    logic [3:0]         channel;
    logic signed [31:0] whole_part;
    logic signed [20:0] micro_part;
    logic               read_failed;
  } item_t;

  // Converted reading handed to the record file
  typedef struct packed {
    logic        apply;
    op_e         kind;
    logic [15:0] value;
    logic [15:0] code;
  } conv_t;

  typedef struct packed {
    logic [15:0] latest;
    logic [15:0] minimum;
    logic [15:0] maximum;
    logic [15:0] scale;
  } rec_t;

  typedef struct packed {
    logic [3:0] channel;
    rec_t       rec;
    logic       updated;
  } result_t;

endpackage

// ----- sv/amsm_if.sv -----
// ----------------------------------------------------------------------------
// amsm_in_if / amsm_out_if
// Valid/ready channels for sensor readings and record results.
// ----------------------------------------------------------------------------
interface amsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  channel;
  logic [31:0] whole_part;
  logic [20:0] micro_part;
  logic        read_failed;

  modport source (output valid, operation, channel, whole_part, micro_part, read_failed,
                  input ready);
  modport sink (input valid, operation, channel, whole_part, micro_part, read_failed,
                output ready);
endinterface

interface amsm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_channel;
  logic [15:0] latest_value;
  logic [15:0] minimum_value;
  logic [15:0] maximum_value;
  logic [15:0] scale_code;
  logic        updated;

  modport source (output valid, out_channel, latest_value, minimum_value, maximum_value,
                  scale_code, updated, input ready);
  modport sink (input valid, out_channel, latest_value, minimum_value, maximum_value,
                scale_code, updated, output ready);
endinterface

// ----- sv/amsm_apb_regs.sv -----
// ----------------------------------------------------------------------------
// amsm_apb_regs
// APB configuration registers: monitor enable, doubled channel, doubling enable.
// ----------------------------------------------------------------------------
module amsm_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [amsm_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output amsm_pkg::cfg_t                 cfg_o
);
  import amsm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MON_EN: cfg_q.mon_en <= pwdata[0];
        REG_DBL_CH: cfg_q.dbl_ch <= pwdata[3:0];
        REG_DBL_EN: cfg_q.dbl_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_MON_EN: prdata = {31'd0, cfg_q.mon_en};
      REG_DBL_CH: prdata = {28'd0, cfg_q.dbl_ch};
      REG_DBL_EN: prdata = {31'd0, cfg_q.dbl_en};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/amsm_convert.sv -----
// ----------------------------------------------------------------------------
// amsm_convert
// Turn one reading into a 16-bit record value and scale code.
// ----------------------------------------------------------------------------
module amsm_convert (
  input  amsm_pkg::item_t item_i,
  input  amsm_pkg::cfg_t  cfg_i,
  output amsm_pkg::conv_t conv_o
);
  import amsm_pkg::*;

  logic signed [41:0] whole_k;
  logic               m_neg;
  logic [20:0]        m_abs;
  logic [36:0]        q_prod;
  logic [11:0]        q_mag;
  logic signed [43:0] q_s;
  logic signed [43:0] milli;
  logic [31:0]        raw;
  logic [15:0]        rng_val;
  logic [15:0]        rng_code;
  logic [31:0]        dbl_raw;
  logic [15:0]        volt_val;
  logic               dbl_hit;

  // Milli-units: whole * 1000 + micro / 1000, truncated toward zero
  assign whole_k = $signed(item_i.whole_part) * $signed(42'sd1000);
  assign m_neg   = item_i.micro_part[20];
  assign m_abs   = m_neg ? 21'(-item_i.micro_part) : 21'(item_i.micro_part);
  assign q_prod  = 37'(m_abs[20:3]) * 37'(RECIP_125);
  assign q_mag   = q_prod[RECIP_SHIFT +: 12];
  assign q_s     = m_neg ? -$signed({32'd0, q_mag}) : $signed({32'd0, q_mag});
  assign milli   = 44'(whole_k) + q_s;

  // Autorange source: temperature in milli-units, current as whole part
  assign raw = (item_i.operation == OP_CURR) ? item_i.whole_part : milli[31:0];

  // Shift right until the upper half is clear; leading one picks the shift
  always_comb begin
    logic [4:0] shifts;
    shifts   = 5'd0;
    rng_code = 16'd0;
    for (int i = 0; i < 16; i++) begin
      if (raw[16+i]) begin
        shifts   = 5'(i + 1);
        rng_code = 16'd1 << i;
      end
    end
    rng_val = 16'(raw >> shifts);
  end

  // Voltage: clamp, or double on the configured channel
  assign dbl_hit = cfg_i.dbl_en && (item_i.channel == cfg_i.dbl_ch);
  assign dbl_raw = {milli[30:0], 1'b0};

  always_comb begin
    if (dbl_hit) begin
      volt_val = (|dbl_raw[31:16]) ? VALUE_MAX : dbl_raw[15:0];
    end else if (milli[43]) begin
      volt_val = 16'd0;
    end else begin
      volt_val = (|milli[42:16]) ? VALUE_MAX : milli[15:0];
    end
  end

  always_comb begin
    conv_o.apply = cfg_i.mon_en && !item_i.read_failed && (item_i.operation != OP_RSVD);
    conv_o.kind  = item_i.operation;
    if (item_i.operation == OP_VOLT) begin
      conv_o.value = volt_val;
      conv_o.code  = 16'd0;
    end else begin
      conv_o.value = rng_val;
      conv_o.code  = rng_code;
    end
  end

endmodule

// ----- sv/amsm_record.sv -----
// ----------------------------------------------------------------------------
// amsm_record
// Per-channel record file with read-modify-write and the result register.
// ----------------------------------------------------------------------------
module amsm_record #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [3:0]          channel_i,
  input  amsm_pkg::conv_t     conv_i,
  output amsm_pkg::result_t   res_o
);
  import amsm_pkg::*;

  localparam int unsigned Depth = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [6:0]  ChanLim = 7'(CHANNELS);

  rec_t            store_q [Depth];
  result_t         res_q;
  result_t         res_d;
  rec_t            old_rec;
  rec_t            new_rec;
  logic            in_range;
  logic [IdxW-1:0] idx;

  assign in_range = {3'd0, channel_i} < ChanLim;
  assign idx      = channel_i[IdxW-1:0];
  assign old_rec  = in_range ? store_q[idx] : '0;

  // Update the record: track min/max, temperature resets on scale change
  always_comb begin
    logic [15:0] v;
    v       = conv_i.value;
    new_rec = old_rec;
    new_rec.latest = v;
    if (v > old_rec.maximum) begin
      new_rec.maximum = v;
    end
    if (old_rec.minimum == 16'd0 || v < old_rec.minimum) begin
      new_rec.minimum = v;
    end
    unique case (conv_i.kind)
      OP_TEMP: begin
        if (conv_i.code > old_rec.scale) begin
          new_rec.scale   = conv_i.code;
          new_rec.maximum = v;
        end else if (conv_i.code < old_rec.scale) begin
          new_rec.scale   = conv_i.code;
          new_rec.minimum = v;
        end
      end
      OP_CURR: new_rec.scale = conv_i.code;
      OP_VOLT: new_rec.scale = 16'd0;
      default: new_rec = old_rec;
    endcase
  end

  // Result as the record stands after this reading
  always_comb begin
    res_d.channel = channel_i;
    res_d.rec     = (in_range && conv_i.apply) ? new_rec : old_rec;
    res_d.updated = in_range && conv_i.apply && (new_rec != old_rec);
  end

  // Write back the record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        store_q[i] <= '0;
      end
    end else if (fire_i && in_range && conv_i.apply) begin
      store_q[idx] <= new_rec;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- sv/autorange_min_max_sensor_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// autorange_min_max_sensor_monitor_unit
// Path: input word accepted into the input register, then conversion and record
//   update into the result register.
// Throughput: one word per cycle unless the result side stalls; the record read-modify-write closes in the same cycle.
// Reset: asynchronous, clears all records, configuration and valid flags.
// ----------------------------------------------------------------------------
module autorange_min_max_sensor_monitor_unit #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  amsm_in_if.sink                     in_i,
  amsm_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [amsm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import amsm_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  logic    out_vld_q;
  logic    fire;
  logic    in_take;
  conv_t   conv;
  result_t res;

  amsm_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Advance when the result register is free or being drained
  assign fire       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || fire;
  assign in_take    = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.operation   <= op_e'(in_i.operation);
      item_q.channel     <= in_i.channel;
      item_q.whole_part  <= in_i.whole_part;
      item_q.micro_part  <= in_i.micro_part;
      item_q.read_failed <= in_i.read_failed;
    end
  end

  amsm_convert u_conv (
    .item_i(item_q),
    .cfg_i (cfg),
    .conv_o(conv)
  );

  amsm_record #(.CHANNELS(CHANNELS)) u_rec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .channel_i(item_q.channel),
    .conv_i   (conv),
    .res_o    (res)
  );

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.out_channel   = res.channel;
  assign out_o.latest_value  = res.rec.latest;
  assign out_o.minimum_value = res.rec.minimum;
  assign out_o.maximum_value = res.rec.maximum;
  assign out_o.scale_code    = res.rec.scale;
  assign out_o.updated       = res.updated;

endmodule

// ----- sv/amsm_checker.sv -----
// ----------------------------------------------------------------------------
// amsm_checker
// Port-level checks for the sensor min/max monitor, bound to the top level.
// ----------------------------------------------------------------------------
module amsm_checker #(
  parameter int unsigned CHANNELS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  out_channel_i,
  input logic [15:0] latest_value_i,
  input logic [15:0] minimum_value_i,
  input logic [15:0] maximum_value_i,
  input logic [15:0] scale_code_i,
  input logic        updated_i
);

  localparam logic [6:0] ChanLim = 7'(CHANNELS);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(latest_value_i)
      && $stable(scale_code_i) && $stable(out_channel_i))
    else $error("stalled result changed");

  // Accept input whenever the output side is empty
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // Scale code is zero or a single bit, and a scaled value has its top bit set
  a_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0(scale_code_i)
      && (scale_code_i == 16'd0 || latest_value_i[15]))
    else $error("scale code inconsistent with latest value");

  // Channels beyond the record file report an empty, unchanged record
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ({3'd0, out_channel_i} >= ChanLim) |->
      !updated_i && latest_value_i == 16'd0 && minimum_value_i == 16'd0
      && maximum_value_i == 16'd0 && scale_code_i == 16'd0)
    else $error("out of range channel reported data");

  // An unused input valid must not raise the output on its own
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !(in_valid_i && in_ready_i) ##1 !out_valid_i && $past(in_ready_i)
      |=> !out_valid_i || $past(in_valid_i && in_ready_i))
    else $error("result without input");

endmodule

bind autorange_min_max_sensor_monitor_unit amsm_checker #(.CHANNELS(CHANNELS)) u_amsm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_channel_i  (out_o.out_channel),
  .latest_value_i (out_o.latest_value),
  .minimum_value_i(out_o.minimum_value),
  .maximum_value_i(out_o.maximum_value),
  .scale_code_i   (out_o.scale_code),
  .updated_i      (out_o.updated)
);

// ----- sim/amsm_record_checker.sv -----
// ----------------------------------------------------------------------------
// amsm_record_checker
// Watches the reading and result channels and the register port of the sensor
// min/max monitor, keeps its own copy of the per-channel records, predicts the
// result word of every accepted reading and compares it field by field.
// ----------------------------------------------------------------------------
module amsm_record_checker #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  amsm_in_if                            in_mon,
  amsm_out_if                           out_mon,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [amsm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            fail_count_o,
  output int                            pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import amsm_pkg::*;

  logic [15:0] latest_mem  [CHANNELS];
  logic [15:0] minimum_mem [CHANNELS];
  logic [15:0] maximum_mem [CHANNELS];
  logic [15:0] scale_mem   [CHANNELS];
  cfg_t        cfg;

  result_t     expected_records[$];
  int          mismatches = 0;
  int          pending_words = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_words;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  // Shift right until the value fits 16 bits; code is 2^(shifts-1), 0 if none
  function automatic logic [15:0] fit_16(input logic [31:0] raw, output logic [15:0] code);
    logic [31:0] v;
    int          shifts;
    v = raw;
    shifts = 0;
    while (v[31:16] != 16'd0) begin
      v = v >> 1;
      shifts++;
    end
    code = (shifts == 0) ? 16'd0 : 16'(32'd1 << (shifts - 1));
    return v[15:0];
  endfunction

  // Raise the maximum, set the minimum when unset or undercut
  function automatic void track_range(input int ch, input logic [15:0] v);
    if (v > maximum_mem[ch]) maximum_mem[ch] = v;
    if (minimum_mem[ch] == 16'd0 || v < minimum_mem[ch]) minimum_mem[ch] = v;
  endfunction

  // Update the record of one reading and return the result word it causes
  function automatic result_t apply_reading(input item_t rd);
    result_t     r;
    rec_t        prior;
    longint      milli;
    logic [15:0] v;
    logic [15:0] code;
    logic [31:0] mv;
    int          ch;
    ch = int'(rd.channel);
    // Channels past the record file report an empty, unchanged record
    if (ch >= int'(CHANNELS)) begin
      r = '0;
      r.channel = rd.channel;
      return r;
    end
    prior.latest  = latest_mem[ch];
    prior.minimum = minimum_mem[ch];
    prior.maximum = maximum_mem[ch];
    prior.scale   = scale_mem[ch];
    r.channel = rd.channel;
    r.updated = 1'b0;
    if (cfg.mon_en && !rd.read_failed && rd.operation != OP_RSVD) begin
      milli = longint'($signed(rd.whole_part)) * 1000 + longint'($signed(rd.micro_part)) / 1000;
      case (rd.operation)
        OP_TEMP: begin
          v = fit_16(milli[31:0], code);
          latest_mem[ch] = v;
          // a coarser scale restarts the maximum, a finer one the minimum
          if (code > prior.scale) begin
            scale_mem[ch]   = code;
            maximum_mem[ch] = v;
          end else if (v > maximum_mem[ch]) begin
            maximum_mem[ch] = v;
          end
          if (minimum_mem[ch] == 16'd0 || v < minimum_mem[ch]) minimum_mem[ch] = v;
          if (code < prior.scale) begin
            scale_mem[ch]   = code;
            minimum_mem[ch] = v;
          end
        end
        OP_CURR: begin
          v = fit_16(rd.whole_part, code);
          latest_mem[ch] = v;
          scale_mem[ch]  = code;
          track_range(ch, v);
        end
        default: begin
          if (cfg.dbl_en && rd.channel == cfg.dbl_ch) begin
            mv = {milli[30:0], 1'b0};
            v  = (mv > 32'd65535) ? VALUE_MAX : mv[15:0];
          end else if (milli < 0) begin
            v = 16'd0;
          end else begin
            v = (milli > 65535) ? VALUE_MAX : milli[15:0];
          end
          latest_mem[ch] = v;
          track_range(ch, v);
          scale_mem[ch] = 16'd0;
        end
      endcase
    end
    r.rec.latest  = latest_mem[ch];
    r.rec.minimum = minimum_mem[ch];
    r.rec.maximum = maximum_mem[ch];
    r.rec.scale   = scale_mem[ch];
    r.updated     = (r.rec != prior);
    return r;
  endfunction

  // Compare results first, then predict the reading taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    item_t   rd;
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        latest_mem[i]  = '0;
        minimum_mem[i] = '0;
        maximum_mem[i] = '0;
        scale_mem[i]   = '0;
      end
      cfg = '0;
      expected_records.delete();
      pending_words = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_records.size() == 0) begin
          report_mismatch($sformatf("result word ch %0d with nothing expected",
                                    out_mon.out_channel));
        end else begin
          want = expected_records.pop_front();
          if (out_mon.out_channel !== want.channel)
            report_mismatch($sformatf("out_channel %0d, want %0d",
                                      out_mon.out_channel, want.channel));
          if (out_mon.latest_value !== want.rec.latest)
            report_mismatch($sformatf("ch %0d latest_value %0d, want %0d",
                                      want.channel, out_mon.latest_value, want.rec.latest));
          if (out_mon.minimum_value !== want.rec.minimum)
            report_mismatch($sformatf("ch %0d minimum_value %0d, want %0d",
                                      want.channel, out_mon.minimum_value, want.rec.minimum));
          if (out_mon.maximum_value !== want.rec.maximum)
            report_mismatch($sformatf("ch %0d maximum_value %0d, want %0d",
                                      want.channel, out_mon.maximum_value, want.rec.maximum));
          if (out_mon.scale_code !== want.rec.scale)
            report_mismatch($sformatf("ch %0d scale_code %0d, want %0d",
                                      want.channel, out_mon.scale_code, want.rec.scale));
          if (out_mon.updated !== want.updated)
            report_mismatch($sformatf("ch %0d updated %0b, want %0b",
                                      want.channel, out_mon.updated, want.updated));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        rd.operation   = op_e'(in_mon.operation);
        rd.channel     = in_mon.channel;
        rd.whole_part  = in_mon.whole_part;
        rd.micro_part  = in_mon.micro_part;
        rd.read_failed = in_mon.read_failed;
        expected_records.push_back(apply_reading(rd));
      end
      pending_words = expected_records.size();
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MON_EN: cfg.mon_en = pwdata[0];
          REG_DBL_CH: cfg.dbl_ch = pwdata[3:0];
          REG_DBL_EN: cfg.dbl_en = pwdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/tb_autorange_min_max_sensor_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// tb_autorange_min_max_sensor_monitor_unit
// Drives directed and random sensor readings through the monitor under a
// series of register settings, with random idling on both channels and one
// long result stall; the record checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_autorange_min_max_sensor_monitor_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import amsm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int                fail_count;
  int                pending;
  int                cycle_count = 0;
  int                items_sent = 0;
  int                gap_pct = 25;
  bit                quiet = 1'b0;
  bit                holding = 1'b0;
  bit                hold_done = 1'b0;

  amsm_in_if  in_if ();
  amsm_out_if out_if ();

  autorange_min_max_sensor_monitor_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  amsm_record_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("autorange_min_max_sensor_monitor_unit test failed");
      $finish;
    end
  end

  function automatic item_t mk_reading(input op_e op, input logic [3:0] ch, input int whole,
                                       input int micro, input bit failed);
    item_t rd;
    rd.operation   = op;
    rd.channel     = ch;
    rd.whole_part  = whole;
    rd.micro_part  = micro[20:0];
    rd.read_failed = failed;
    return rd;
  endfunction

  // Mostly readings near the unscaled range, some spanning every magnitude
  function automatic item_t random_reading(input logic [3:0] hot_ch);
    int   pick;
    int   whole;
    op_e  op;
    logic [3:0] ch;
    pick = $urandom_range(0, 99);
    op = (pick < 40) ? OP_TEMP : (pick < 70) ? OP_VOLT : (pick < 97) ? OP_CURR : OP_RSVD;
    pick = $urandom_range(0, 9);
    ch = (pick < 2) ? hot_ch : (pick < 6) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick < 6)       whole = $urandom_range(0, 80);
    else if (pick < 8)  whole = int'($urandom >> $urandom_range(0, 31));
    else if (pick == 8) whole = -int'($urandom_range(0, 500));
    else                whole = int'($urandom);
    return mk_reading(op, ch, whole, int'($urandom_range(0, 1999998)) - 999999,
                      $urandom_range(0, 9) == 0);
  endfunction

  // Offer one word, hold it until taken, then maybe idle
  task automatic send_reading(input item_t rd);
    in_if.valid       = 1'b1;
    in_if.operation   = rd.operation;
    in_if.channel     = rd.channel;
    in_if.whole_part  = rd.whole_part;
    in_if.micro_part  = rd.micro_part;
    in_if.read_failed = rd.read_failed;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    if (!quiet && !holding && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drain outstanding results before touching the registers
  task automatic settle();
    in_if.valid = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_config(input bit en, input logic [3:0] dch, input bit den);
    settle();
    apb_write(REG_MON_EN, {31'd0, en});
    apb_write(REG_DBL_CH, {28'd0, dch});
    apb_write(REG_DBL_EN, {31'd0, den});
  endtask

  // Result side: random stalls, one long hold-off, none at the tail
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!hold_done && items_sent >= 300) begin
        holding = 1'b1;
        out_if.ready = 1'b0;
        repeat (150) @(negedge clk_i);
        holding = 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end else begin
        out_if.ready = 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 30)) @(negedge clk_i);
      end
    end
  end

  initial begin
    logic [3:0] dch;
    bit         en;
    bit         den;
    int         count;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.operation   = OP_TEMP;
    in_if.channel     = '0;
    in_if.whole_part  = '0;
    in_if.micro_part  = '0;
    in_if.read_failed = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Monitor still off after reset: records must not move
    send_reading(mk_reading(OP_TEMP, 4'd0, 25, 0, 1'b0));
    send_reading(mk_reading(OP_VOLT, 4'd1, 3, 0, 1'b0));

    write_config(1'b1, 4'd15, 1'b1);
    // Temperature: unscaled, scale up restarts max, scale down restarts min
    send_reading(mk_reading(OP_TEMP, 4'd0, 25, 500000, 1'b0));
    send_reading(mk_reading(OP_TEMP, 4'd0, 100, 0, 1'b0));
    send_reading(mk_reading(OP_TEMP, 4'd0, 20, 0, 1'b0));
    send_reading(mk_reading(OP_TEMP, 4'd1, -1, -1, 1'b0));
    send_reading(mk_reading(OP_TEMP, 4'd1, 32'h7FFFFFFF, 999999, 1'b0));
    send_reading(mk_reading(OP_TEMP, 4'd2, 32'h80000000, -999999, 1'b0));
    send_reading(mk_reading(OP_TEMP, 4'd2, 0, 0, 1'b0));
    // Current: extremes and the 16-bit boundary
    send_reading(mk_reading(OP_CURR, 4'd3, 32'h7FFFFFFF, 0, 1'b0));
    send_reading(mk_reading(OP_CURR, 4'd3, 32'h80000000, 0, 1'b0));
    send_reading(mk_reading(OP_CURR, 4'd3, 1, 999999, 1'b0));
    send_reading(mk_reading(OP_CURR, 4'd3, 65536, 0, 1'b0));
    // Voltage: plain, negative clamp, saturation
    send_reading(mk_reading(OP_VOLT, 4'd4, 3, 300000, 1'b0));
    send_reading(mk_reading(OP_VOLT, 4'd4, -5, 0, 1'b0));
    send_reading(mk_reading(OP_VOLT, 4'd4, 70, 0, 1'b0));
    send_reading(mk_reading(OP_VOLT, 4'd4, 0, -999999, 1'b0));
    send_reading(mk_reading(OP_VOLT, 4'd6, 0, 999999, 1'b0));
    // Voltage on the doubled channel, negative wraps before doubling
    send_reading(mk_reading(OP_VOLT, 4'd15, 40, 0, 1'b0));
    send_reading(mk_reading(OP_VOLT, 4'd15, 1, 234567, 1'b0));
    send_reading(mk_reading(OP_VOLT, 4'd15, -1, 0, 1'b0));
    send_reading(mk_reading(OP_VOLT, 4'd15, 32'h7FFFFFFF, 999999, 1'b0));
    // Reserved kind and failed fetch leave the record alone
    send_reading(mk_reading(OP_RSVD, 4'd5, 10, 0, 1'b0));
    send_reading(mk_reading(OP_TEMP, 4'd0, 30, 0, 1'b1));

    // Random phases under changing register settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       begin en = 1'b1; dch = 4'd0;  den = 1'b0; end
        1:       begin en = 1'b1; dch = 4'd0;  den = 1'b1; end
        2:       begin en = 1'b0; dch = 4'd7;  den = 1'b1; end
        3:       begin en = 1'b1; dch = 4'd15; den = 1'b1; end
        default: begin
          en  = 1'b1;
          dch = 4'($urandom_range(0, 15));
          den = 1'($urandom_range(0, 1));
        end
      endcase
      write_config(en, dch, den);
      count = (p == 2) ? 60 : 195;
      for (int i = 0; i < count; i++) begin
        if (i % 40 == 0) gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        quiet = (p == 4 && i >= 115);
        send_reading(random_reading(dch));
      end
    end

    // Drain and let the pipeline run dry
    in_if.valid = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("autorange_min_max_sensor_monitor_unit test passed");
    end else begin
      $display("autorange_min_max_sensor_monitor_unit test failed");
    end
    $finish;
  end

endmodule
